### hdl/c2e_pkg.sv
// c2e_pkg: shared types for the cigar text to exon coordinate core
// holds the queue item, result record, phase and code enums
// no dependencies
`default_nettype none

package c2e_pkg;

    localparam int LEN_W = 28;

    // character class decided by the front end
    typedef enum logic [2:0] {
        CMD_DIGIT,
        CMD_OP,
        CMD_END,
        CMD_STAR,
        CMD_BAD
    } t_cmd;

    // cigar operation codes as they appear in the packed word
    typedef enum logic [2:0] {
        OP_MATCH = 3'd0,
        OP_INS   = 3'd1,
        OP_DEL   = 3'd2,
        OP_SKIP  = 3'd3,
        OP_SOFT  = 3'd4,
        OP_HARD  = 3'd5,
        OP_PAD   = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        KIND_WORD     = 3'd0,
        KIND_EXON     = 3'd1,
        KIND_MAPPED   = 3'd2,
        KIND_UNMAPPED = 3'd3,
        KIND_ERROR    = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_BODY,
        PH_STAR,
        PH_SKIP
    } t_phase;

    // one classified character
    typedef struct packed {
        t_cmd        cmd;
        t_op         op;
        logic [3:0]  digit;
        logic        first;
        logic [31:0] pos;
        logic        unm;
    } t_item;

    typedef struct packed {
        t_kind              kind;
        logic [31:0]        cigar_word;
        logic [31:0]        exon_start;
        logic [31:0]        exon_end;
        logic [30:0]        aligned_bases;
        logic [LEN_W-1:0]   clip_left;
        logic [LEN_W-1:0]   clip_right;
        logic               spliced;
        logic               soft_clip_flag;
        logic               hard_clip_flag;
        logic               last;
    } t_result;

endpackage

`default_nettype wire

### hdl/c2e_front.sv
// c2e_front: input handshake and character classification
// depends on c2e_pkg
`default_nettype none

module c2e_front (
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [7:0]        i_ch,
    input  wire logic              i_first,
    input  wire logic [31:0]       i_record_pos,
    input  wire logic              i_unmapped,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output c2e_pkg::t_item         o_item
);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'd32;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_P     = 8'h50;

    logic [7:0]      uc;
    logic            op_ok;
    c2e_pkg::t_op    op;
    logic [7:0]      dig;

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // fold lower case letters onto upper case
    assign uc  = (i_ch >= CH_LC_A && i_ch <= CH_LC_Z) ? i_ch - CASE_OFS : i_ch;
    assign dig = i_ch - CH_ZERO;

    always_comb begin
        op_ok = 1'b1;
        op    = c2e_pkg::OP_MATCH;
        unique case (uc)
            CH_M, CH_EQ, CH_X: op = c2e_pkg::OP_MATCH;
            CH_I:              op = c2e_pkg::OP_INS;
            CH_D:              op = c2e_pkg::OP_DEL;
            CH_N:              op = c2e_pkg::OP_SKIP;
            CH_S:              op = c2e_pkg::OP_SOFT;
            CH_H:              op = c2e_pkg::OP_HARD;
            CH_P:              op = c2e_pkg::OP_PAD;
            default:           op_ok = 1'b0;
        endcase
    end

    always_comb begin
        o_item.op    = op;
        o_item.digit = dig[3:0];
        o_item.first = i_first;
        o_item.pos   = i_record_pos;
        o_item.unm   = i_unmapped;
        if (i_ch == CH_NUL) begin
            o_item.cmd = c2e_pkg::CMD_END;
        end else if (i_ch == CH_STAR) begin
            o_item.cmd = c2e_pkg::CMD_STAR;
        end else if (i_ch >= CH_ZERO && i_ch <= CH_NINE) begin
            o_item.cmd = c2e_pkg::CMD_DIGIT;
        end else if (op_ok) begin
            o_item.cmd = c2e_pkg::CMD_OP;
        end else begin
            o_item.cmd = c2e_pkg::CMD_BAD;
        end
    end

endmodule

`default_nettype wire

### hdl/c2e_queue.sv
// c2e_queue: small register queue between front and back
// depends on c2e_pkg
`default_nettype none

module c2e_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire c2e_pkg::t_item    i_item,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output c2e_pkg::t_item         o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    c2e_pkg::t_item    r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_full) |-> i_pop)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

### hdl/c2e_back.sv
// c2e_back: record state, length accumulation, exon tracking and result output
// depends on c2e_pkg
`default_nettype none

module c2e_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire c2e_pkg::t_item    i_item,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output c2e_pkg::t_result       o_res
);

    localparam int LW = c2e_pkg::LEN_W;

    // record state
    c2e_pkg::t_phase   r_phase, n_phase;
    logic [LW-1:0]     r_accum, n_accum;
    logic              r_dp, n_dp;
    logic [31:0]       r_start_p1, n_start_p1;
    logic              r_unm, n_unm;
    logic [31:0]       r_span, n_span;
    logic [31:0]       r_cur_end, n_cur_end;   // start + span
    logic [31:0]       r_eb_p1, n_eb_p1;       // open exon start, one-based
    logic [31:0]       r_mte, n_mte;           // mapped total minus exon begin
    logic [LW-1:0]     r_clip_l, n_clip_l;
    logic [LW-1:0]     r_clip_r, n_clip_r;
    logic              r_introns, n_introns;
    logic              r_soft, n_soft;
    logic              r_hard, n_hard;

    // state after a first mark
    c2e_pkg::t_phase   b_phase;
    logic [LW-1:0]     b_accum;
    logic              b_dp;
    logic [31:0]       b_start_p1;
    logic              b_unm;
    logic [31:0]       b_span;
    logic [31:0]       b_cur_end;
    logic [31:0]       b_eb_p1;
    logic [31:0]       b_mte;
    logic [LW-1:0]     b_clip_l;
    logic [LW-1:0]     b_clip_r;
    logic              b_introns;
    logic              b_soft;
    logic              b_hard;

    // output register and second-result holding stage
    logic              r_out_valid;
    c2e_pkg::t_result  r_out;
    logic              r_pend_valid;
    c2e_pkg::t_result  r_pend;

    c2e_pkg::t_result  res0, res1;
    logic              emit0, emit1;
    logic              out_free, take;
    logic [31:0]       dig_sum;
    logic              dig_ovf;
    logic [31:0]       len32;

    assign out_free = !r_out_valid || i_out_ready;
    assign take     = i_q_valid && out_free && !r_pend_valid;
    assign o_pop    = take;
    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

    always_comb begin
        if (i_item.first) begin
            b_phase    = c2e_pkg::PH_START;
            b_accum    = '0;
            b_dp       = 1'b0;
            b_start_p1 = i_item.pos + 32'd1;
            b_unm      = i_item.unm;
            b_span     = '0;
            b_cur_end  = i_item.pos;
            b_eb_p1    = i_item.pos + 32'd1;
            b_mte      = 32'd0 - i_item.pos;
            b_clip_l   = '0;
            b_clip_r   = '0;
            b_introns  = 1'b0;
            b_soft     = 1'b0;
            b_hard     = 1'b0;
        end else begin
            b_phase    = r_phase;
            b_accum    = r_accum;
            b_dp       = r_dp;
            b_start_p1 = r_start_p1;
            b_unm      = r_unm;
            b_span     = r_span;
            b_cur_end  = r_cur_end;
            b_eb_p1    = r_eb_p1;
            b_mte      = r_mte;
            b_clip_l   = r_clip_l;
            b_clip_r   = r_clip_r;
            b_introns  = r_introns;
            b_soft     = r_soft;
            b_hard     = r_hard;
        end
    end

    // accum * 10 + digit as two shifts and adds
    assign dig_sum = ({4'b0, b_accum} << 3) + ({4'b0, b_accum} << 1) + {28'b0, i_item.digit};
    assign dig_ovf = |dig_sum[31:LW];
    assign len32   = {{(32-LW){1'b0}}, b_accum};

    // next phase
    always_comb begin
        n_phase = b_phase;
        unique case (b_phase)
            c2e_pkg::PH_IDLE: n_phase = c2e_pkg::PH_IDLE;
            c2e_pkg::PH_SKIP, c2e_pkg::PH_STAR: begin
                n_phase = (i_item.cmd == c2e_pkg::CMD_END) ? c2e_pkg::PH_IDLE
                                                            : c2e_pkg::PH_SKIP;
            end
            c2e_pkg::PH_START, c2e_pkg::PH_BODY: begin
                unique case (i_item.cmd)
                    c2e_pkg::CMD_END:
                        n_phase = b_dp ? c2e_pkg::PH_SKIP : c2e_pkg::PH_IDLE;
                    c2e_pkg::CMD_STAR:
                        n_phase = (b_phase == c2e_pkg::PH_START) ? c2e_pkg::PH_STAR
                                                                 : c2e_pkg::PH_SKIP;
                    c2e_pkg::CMD_DIGIT:
                        n_phase = dig_ovf ? c2e_pkg::PH_SKIP : c2e_pkg::PH_BODY;
                    c2e_pkg::CMD_OP:
                        n_phase = c2e_pkg::PH_BODY;
                    default:
                        n_phase = c2e_pkg::PH_SKIP;
                endcase
            end
            default: n_phase = c2e_pkg::PH_IDLE;
        endcase
    end

    // datapath and results
    always_comb begin
        n_accum    = b_accum;
        n_dp       = b_dp;
        n_start_p1 = b_start_p1;
        n_unm      = b_unm;
        n_span     = b_span;
        n_cur_end  = b_cur_end;
        n_eb_p1    = b_eb_p1;
        n_mte      = b_mte;
        n_clip_l   = b_clip_l;
        n_clip_r   = b_clip_r;
        n_introns  = b_introns;
        n_soft     = b_soft;
        n_hard     = b_hard;
        res0  = '0;
        res1  = '0;
        emit0 = 1'b0;
        emit1 = 1'b0;
        unique case (b_phase)
            c2e_pkg::PH_STAR: begin
                emit0      = 1'b1;
                res0.last  = 1'b1;
                res0.kind  = (i_item.cmd == c2e_pkg::CMD_END) ? c2e_pkg::KIND_UNMAPPED
                                                               : c2e_pkg::KIND_ERROR;
            end
            c2e_pkg::PH_START, c2e_pkg::PH_BODY: begin
                unique case (i_item.cmd)
                    c2e_pkg::CMD_END: begin
                        emit0 = 1'b1;
                        if (b_dp) begin
                            // digits with no operation letter
                            res0.kind = c2e_pkg::KIND_ERROR;
                            res0.last = 1'b1;
                        end else if (b_unm) begin
                            res0.kind = c2e_pkg::KIND_UNMAPPED;
                            res0.last = 1'b1;
                        end else begin
                            // closing exon, then the summary
                            emit1               = 1'b1;
                            res0.kind           = c2e_pkg::KIND_EXON;
                            res0.exon_start     = b_eb_p1;
                            res0.exon_end       = b_cur_end;
                            res1.kind           = c2e_pkg::KIND_MAPPED;
                            res1.exon_start     = b_start_p1;
                            res1.exon_end       = b_cur_end;
                            res1.aligned_bases  = 31'(b_mte + b_cur_end);
                            res1.clip_left      = b_clip_l;
                            res1.clip_right     = b_clip_r;
                            res1.spliced        = b_introns;
                            res1.soft_clip_flag = b_soft;
                            res1.hard_clip_flag = b_hard;
                            res1.last           = 1'b1;
                        end
                    end
                    c2e_pkg::CMD_STAR: begin
                        // star is only legal as the whole string
                        if (b_phase == c2e_pkg::PH_BODY) begin
                            emit0     = 1'b1;
                            res0.kind = c2e_pkg::KIND_ERROR;
                            res0.last = 1'b1;
                        end
                    end
                    c2e_pkg::CMD_DIGIT: begin
                        if (dig_ovf) begin
                            emit0     = 1'b1;
                            res0.kind = c2e_pkg::KIND_ERROR;
                            res0.last = 1'b1;
                        end else begin
                            n_accum = dig_sum[LW-1:0];
                            n_dp    = 1'b1;
                        end
                    end
                    c2e_pkg::CMD_OP: begin
                        emit0           = 1'b1;
                        res0.kind       = c2e_pkg::KIND_WORD;
                        res0.cigar_word = {b_accum, 1'b0, i_item.op};
                        n_accum         = '0;
                        n_dp            = 1'b0;
                        case (i_item.op) inside
                            c2e_pkg::OP_MATCH, c2e_pkg::OP_DEL: begin
                                n_span    = b_span + len32;
                                n_cur_end = b_cur_end + len32;
                            end
                            c2e_pkg::OP_SKIP: begin
                                n_introns = 1'b1;
                                if (!b_unm) begin
                                    emit1           = 1'b1;
                                    res1.kind       = c2e_pkg::KIND_EXON;
                                    res1.exon_start = b_eb_p1;
                                    res1.exon_end   = b_cur_end;
                                end
                                // running total moves with the new exon begin
                                n_mte     = b_mte - len32;
                                n_span    = b_span + len32;
                                n_cur_end = b_cur_end + len32;
                                n_eb_p1   = b_cur_end + len32 + 32'd1;
                            end
                            c2e_pkg::OP_SOFT: begin
                                n_soft = 1'b1;
                                if (b_span != '0) begin
                                    n_clip_r = b_accum;
                                end else begin
                                    n_clip_l = b_accum;
                                end
                            end
                            c2e_pkg::OP_HARD: n_hard = 1'b1;
                            default: ;
                        endcase
                    end
                    default: begin
                        emit0     = 1'b1;
                        res0.kind = c2e_pkg::KIND_ERROR;
                        res0.last = 1'b1;
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= c2e_pkg::PH_IDLE;
        end else if (take) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_accum    <= n_accum;
            r_dp       <= n_dp;
            r_start_p1 <= n_start_p1;
            r_unm      <= n_unm;
            r_span     <= n_span;
            r_cur_end  <= n_cur_end;
            r_eb_p1    <= n_eb_p1;
            r_mte      <= n_mte;
            r_clip_l   <= n_clip_l;
            r_clip_r   <= n_clip_r;
            r_introns  <= n_introns;
            r_soft     <= n_soft;
            r_hard     <= n_hard;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (out_free) begin
            if (r_pend_valid) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else begin
                r_out_valid  <= take && emit0;
                r_pend_valid <= take && emit1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_pend_valid) begin
                r_out <= r_pend;
            end else begin
                r_out  <= res0;
                r_pend <= res1;
            end
        end
    end

    a_pend_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_out_valid)
        else $error("second result held without a first");

    a_pend_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_pend.kind == c2e_pkg::KIND_EXON ||
                          r_pend.kind == c2e_pkg::KIND_MAPPED))
        else $error("unexpected second result kind");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

### hdl/cigar_text_to_exon_coordinates_core.sv
// cigar_text_to_exon_coordinates_core: a request's first result passes a queue entry, then
// the output register; a second result follows once the first is taken; throughput
// 1 character per cycle while queue has room; in a mapped record an N or a clean end each
// make two results and hold the back end while the second waits, the queue absorbs
// reset is synchronous, active low: clears parse phase, queue and output valid; no clear pass
`default_nettype none

module cigar_text_to_exon_coordinates_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // character requests
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [7:0]         i_ch,
    input  wire logic               i_first,
    input  wire logic signed [31:0] i_record_pos,
    input  wire logic               i_unmapped,
    // results
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [2:0]              o_kind,
    output logic [31:0]             o_cigar_word,
    output logic signed [31:0]      o_exon_start,
    output logic signed [31:0]      o_exon_end,
    output logic [30:0]             o_aligned_bases,
    output logic [27:0]             o_clip_left,
    output logic [27:0]             o_clip_right,
    output logic                    o_spliced,
    output logic                    o_soft_clip_flag,
    output logic                    o_hard_clip_flag,
    output logic                    o_last
);

    logic               q_full;
    logic               push;
    c2e_pkg::t_item     front_item;
    logic               q_valid;
    logic               pop;
    c2e_pkg::t_item     q_item;
    c2e_pkg::t_result   res;

    // front end: takes a request whenever the queue has room and tags the character
    c2e_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_ch         (i_ch),
        .i_first      (i_first),
        .i_record_pos (i_record_pos),
        .i_unmapped   (i_unmapped),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_item       (front_item)
    );

    // decouples input acceptance from back end stalls on the result side
    c2e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // back end: record state, exon bookkeeping and the registered result stage
    c2e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_item      (q_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (res)
    );

    // unpack the result record onto the ports
    assign o_kind           = res.kind;
    assign o_cigar_word     = res.cigar_word;
    assign o_exon_start     = $signed(res.exon_start);
    assign o_exon_end       = $signed(res.exon_end);
    assign o_aligned_bases  = res.aligned_bases;
    assign o_clip_left      = res.clip_left;
    assign o_clip_right     = res.clip_right;
    assign o_spliced        = res.spliced;
    assign o_soft_clip_flag = res.soft_clip_flag;
    assign o_hard_clip_flag = res.hard_clip_flag;
    assign o_last           = res.last;

endmodule

`default_nettype wire

### dv/cigar_text_to_exon_coordinates_core_test.sv
// cigar_text_to_exon_coordinates_core_test: self-checking bench for the cigar text core
// streams cigar characters over valid/ready and predicts words, exons and summaries
// depends on c2e_pkg and cigar_text_to_exon_coordinates_core
`timescale 1ns / 100ps

module cigar_text_to_exon_coordinates_core_test;

    localparam logic [27:0] LEN_MAX = 28'hFFF_FFFF;

    // one character request as the sender presents it
    typedef struct {
        logic [7:0]  ch;
        logic        first;
        logic [31:0] pos;
        logic        unm;
    } t_cigar_char;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [7:0]         i_ch = '0;
    logic               i_first = 1'b0;
    logic signed [31:0] i_record_pos = '0;
    logic               i_unmapped = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [2:0]         o_kind;
    logic [31:0]        o_cigar_word;
    logic signed [31:0] o_exon_start;
    logic signed [31:0] o_exon_end;
    logic [30:0]        o_aligned_bases;
    logic [27:0]        o_clip_left;
    logic [27:0]        o_clip_right;
    logic               o_spliced;
    logic               o_soft_clip_flag;
    logic               o_hard_clip_flag;
    logic               o_last;

    cigar_text_to_exon_coordinates_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_ch             (i_ch),
        .i_first          (i_first),
        .i_record_pos     (i_record_pos),
        .i_unmapped       (i_unmapped),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_cigar_word     (o_cigar_word),
        .o_exon_start     (o_exon_start),
        .o_exon_end       (o_exon_end),
        .o_aligned_bases  (o_aligned_bases),
        .o_clip_left      (o_clip_left),
        .o_clip_right     (o_clip_right),
        .o_spliced        (o_spliced),
        .o_soft_clip_flag (o_soft_clip_flag),
        .o_hard_clip_flag (o_hard_clip_flag),
        .o_last           (o_last)
    );

    // characters waiting to be sent, and results the parser still owes
    t_cigar_char         chars_to_send[$];
    c2e_pkg::t_result    results_due[$];

    int  n_fail = 0;
    int  send_idle_pct = 0;
    int  sink_stall_pct = 0;
    int  chars_queued = 0;
    bit  req_taken = 1'b0;

    // start-of-record fields for the next character pushed
    bit          next_first = 1'b0;
    logic [31:0] first_pos = '0;
    logic        first_unm = 1'b0;

    string op_letters = "MIDNSHP=X";

    // parser state mirrored from the block
    logic [27:0]     txt_len;
    bit              len_digits_seen;
    logic [31:0]     rec_base;
    bit              rec_unm;
    logic [31:0]     ref_cover;
    logic [31:0]     exon_open_at;
    logic [31:0]     exon_total;
    logic [27:0]     soft_left;
    logic [27:0]     soft_right;
    bit              intron_seen;
    bit              soft_seen;
    bit              hard_seen;
    c2e_pkg::t_phase parse_st;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // cigar parsing prediction
    // ---------------------------------------------------------------

    // case-insensitive letter to op code; 0 for anything that is not an op
    function automatic logic decode_op(input logic [7:0] c, output c2e_pkg::t_op op);
        logic [7:0] u;
        u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
        op = c2e_pkg::OP_MATCH;
        decode_op = 1'b1;
        case (u)
            "M", "=", "X": op = c2e_pkg::OP_MATCH;
            "I": op = c2e_pkg::OP_INS;
            "D": op = c2e_pkg::OP_DEL;
            "N": op = c2e_pkg::OP_SKIP;
            "S": op = c2e_pkg::OP_SOFT;
            "H": op = c2e_pkg::OP_HARD;
            "P": op = c2e_pkg::OP_PAD;
            default: decode_op = 1'b0;
        endcase
    endfunction

    task automatic clear_record(logic [31:0] pos, logic unm);
        rec_base = pos;
        rec_unm = unm;
        txt_len = '0;
        len_digits_seen = 1'b0;
        ref_cover = '0;
        exon_open_at = pos;
        exon_total = '0;
        soft_left = '0;
        soft_right = '0;
        intron_seen = 1'b0;
        soft_seen = 1'b0;
        hard_seen = 1'b0;
    endtask

    // error and unmapped summary both carry only kind and last
    task automatic push_final(c2e_pkg::t_kind k);
        c2e_pkg::t_result r;
        r = '0;
        r.kind = k;
        r.last = 1'b1;
        results_due.push_back(r);
        if (k == c2e_pkg::KIND_ERROR)
            parse_st = c2e_pkg::PH_SKIP;
    endtask

    // exon from the open start up to the current reference end
    task automatic close_exon();
        c2e_pkg::t_result r;
        logic [31:0]      stop;
        stop = rec_base + ref_cover;
        r = '0;
        r.kind = c2e_pkg::KIND_EXON;
        r.exon_start = exon_open_at + 32'd1;
        r.exon_end = stop;
        exon_total = exon_total + (stop - exon_open_at);
        results_due.push_back(r);
    endtask

    task automatic end_record();
        c2e_pkg::t_result r;
        parse_st = c2e_pkg::PH_IDLE;
        if (len_digits_seen) begin
            // digits with no op letter after them
            push_final(c2e_pkg::KIND_ERROR);
        end else if (rec_unm) begin
            push_final(c2e_pkg::KIND_UNMAPPED);
        end else begin
            close_exon();
            r = '0;
            r.kind = c2e_pkg::KIND_MAPPED;
            r.exon_start = rec_base + 32'd1;
            r.exon_end = rec_base + ref_cover;
            r.aligned_bases = exon_total[30:0];
            r.clip_left = soft_left;
            r.clip_right = soft_right;
            r.spliced = intron_seen;
            r.soft_clip_flag = soft_seen;
            r.hard_clip_flag = hard_seen;
            r.last = 1'b1;
            results_due.push_back(r);
        end
    endtask

    task automatic parse_char(t_cigar_char c);
        c2e_pkg::t_result r;
        c2e_pkg::t_op     op;
        logic [35:0]      acc;
        logic [31:0]      len32;
        if (c.first) begin
            clear_record(c.pos, c.unm);
            parse_st = c2e_pkg::PH_START;
        end
        case (parse_st)
            c2e_pkg::PH_IDLE: return;
            c2e_pkg::PH_SKIP: begin
                if (c.ch == 8'd0)
                    parse_st = c2e_pkg::PH_IDLE;
                return;
            end
            c2e_pkg::PH_STAR: begin
                // a lone star is unmapped, anything after it is an error
                if (c.ch == 8'd0) begin
                    push_final(c2e_pkg::KIND_UNMAPPED);
                    parse_st = c2e_pkg::PH_IDLE;
                end else begin
                    push_final(c2e_pkg::KIND_ERROR);
                end
                return;
            end
            default: ;
        endcase

        if (c.ch == 8'd0) begin
            end_record();
            return;
        end
        if (c.ch == "*" && parse_st == c2e_pkg::PH_START) begin
            parse_st = c2e_pkg::PH_STAR;
            return;
        end
        parse_st = c2e_pkg::PH_BODY;

        if (c.ch >= "0" && c.ch <= "9") begin
            acc = 36'(txt_len) * 36'd10 + 36'(c.ch - "0");
            if (acc > 36'(LEN_MAX)) begin
                push_final(c2e_pkg::KIND_ERROR);
            end else begin
                txt_len = acc[27:0];
                len_digits_seen = 1'b1;
            end
            return;
        end
        if (!decode_op(c.ch, op)) begin
            push_final(c2e_pkg::KIND_ERROR);
            return;
        end

        r = '0;
        r.kind = c2e_pkg::KIND_WORD;
        r.cigar_word = {txt_len, 1'b0, op};
        results_due.push_back(r);
        len32 = {4'd0, txt_len};
        txt_len = '0;
        len_digits_seen = 1'b0;
        case (op)
            c2e_pkg::OP_MATCH, c2e_pkg::OP_DEL: ref_cover = ref_cover + len32;
            c2e_pkg::OP_SKIP: begin
                // the intron closes the open exon, the next starts past it
                intron_seen = 1'b1;
                if (!rec_unm)
                    close_exon();
                ref_cover = ref_cover + len32;
                exon_open_at = rec_base + ref_cover;
            end
            c2e_pkg::OP_SOFT: begin
                soft_seen = 1'b1;
                if (ref_cover != 32'd0)
                    soft_right = len32[27:0];
                else
                    soft_left = len32[27:0];
            end
            c2e_pkg::OP_HARD: hard_seen = 1'b1;
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------

    function automatic logic [31:0] pick_pos();
        case ($urandom_range(0, 9))
            0: pick_pos = 32'hFFFF_FFFF;
            1: pick_pos = 32'h7FFF_FFFF;
            2: pick_pos = $urandom();
            default: pick_pos = $urandom_range(0, 100000);
        endcase
    endfunction

    task automatic start_record(logic [31:0] pos, logic unm);
        next_first = 1'b1;
        first_pos = pos;
        first_unm = unm;
    endtask

    // fields other than ch are don't-care off the first character, so toggle them
    task automatic push_char(logic [7:0] c, bit counted);
        t_cigar_char it;
        it.ch = c;
        it.first = next_first;
        it.pos = next_first ? first_pos : $urandom();
        it.unm = next_first ? first_unm : 1'($urandom_range(0, 1));
        next_first = 1'b0;
        chars_to_send.push_back(it);
        if (counted)
            chars_queued++;
    endtask

    task automatic push_text(string s);
        foreach (s[i])
            push_char(s[i], 1'b1);
    endtask

    // mostly short lengths, some empty, some near or at the 28 bit top
    function automatic string len_text();
        case ($urandom_range(0, 19))
            0, 1: len_text = "";
            2: len_text = "268435455";
            3, 4: len_text = $sformatf("%0d", $urandom_range(0, int'(LEN_MAX)));
            5: len_text = "0";
            6: len_text = $sformatf("00%0d", $urandom_range(1, 99));
            default: len_text = $sformatf("%0d", $urandom_range(1, 300));
        endcase
    endfunction

    function automatic string op_text();
        logic [7:0] c;
        c = op_letters[$urandom_range(0, 8)];
        if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1)
            c = c + 8'd32;
        op_text = $sformatf("%c", c);
    endfunction

    task automatic add_record();
        int           pick;
        int           n_ops;
        string        body;
        string        tail;
        logic [7:0]   junk;
        c2e_pkg::t_op op;
        pick = $urandom_range(0, 99);
        n_ops = $urandom_range(0, 6);
        body = "";
        tail = "";
        for (int i = 0; i < n_ops; i++)
            body = {body, len_text(), op_text()};
        for (int i = 0; i < 2; i++)
            tail = {tail, len_text(), op_text()};
        start_record(pick_pos(), $urandom_range(0, 99) < 15);

        if (pick < 62) begin
            // well-formed record
            push_text(body);
            push_char(8'd0, 1'b1);
        end else if (pick < 70) begin
            // star, alone or followed by something
            push_text("*");
            if ($urandom_range(0, 2) == 0)
                push_text(tail);
            push_char(8'd0, 1'b1);
        end else if (pick < 78) begin
            // character that is neither digit nor op, rest is skipped
            do
                junk = 8'($urandom_range(1, 255));
            while ((junk >= "0" && junk <= "9") || decode_op(junk, op));
            push_text(body);
            push_char(junk, 1'b1);
            push_text(tail);
            push_char(8'd0, 1'b1);
        end else if (pick < 84) begin
            // digits left dangling at the terminator
            push_text(body);
            push_text($sformatf("%0d", $urandom_range(0, 999)));
            push_char(8'd0, 1'b1);
            push_text(tail);
        end else if (pick < 90) begin
            // length one past the 28 bit limit or more
            push_text(body);
            push_text($sformatf("%0d", 64'(LEN_MAX) + 64'd1 + 64'($urandom_range(0, 1 << 20))));
            push_text("M");
            push_char(8'd0, 1'b1);
        end else if (pick < 95) begin
            // cut short, the next record's first drops it
            push_text(body);
            push_text(len_text());
        end else begin
            // characters with no first mark, outside any record unless the last one was cut short
            next_first = 1'b0;
            repeat ($urandom_range(1, 4))
                push_char(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic drain_all();
        while (chars_to_send.size() != 0 || results_due.size() != 0)
            @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // driver: presents the queue head at the falling edge
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin : drive_chars
        if (i_rst_n) begin
            // a held request stays put until the rising edge takes it
            if (!i_in_valid || req_taken) begin
                if (chars_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_ch <= chars_to_send[0].ch;
                    i_first <= chars_to_send[0].first;
                    i_record_pos <= chars_to_send[0].pos;
                    i_unmapped <= chars_to_send[0].unm;
                end else begin
                    i_in_valid <= 1'b0;
                end
                req_taken = 1'b0;
            end
            i_out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // monitor: takes requests into the predictor, checks results
    // ---------------------------------------------------------------
    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endtask

    always @(posedge i_clk) begin : watch_results
        t_cigar_char      c;
        c2e_pkg::t_result want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                c = chars_to_send.pop_front();
                parse_char(c);
                req_taken = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $error("kind: expected no result, got %0d", o_kind);
                    n_fail++;
                end else begin
                    want = results_due.pop_front();
                    check_field("kind", want.kind, o_kind);
                    check_field("cigar_word", want.cigar_word, o_cigar_word);
                    check_field("exon_start", want.exon_start, o_exon_start);
                    check_field("exon_end", want.exon_end, o_exon_end);
                    check_field("aligned_bases", want.aligned_bases, o_aligned_bases);
                    check_field("clip_left", want.clip_left, o_clip_left);
                    check_field("clip_right", want.clip_right, o_clip_right);
                    check_field("spliced", want.spliced, o_spliced);
                    check_field("soft_clip_flag", want.soft_clip_flag, o_soft_clip_flag);
                    check_field("hard_clip_flag", want.hard_clip_flag, o_hard_clip_flag);
                    check_field("last", want.last, o_last);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // run sequence
    // ---------------------------------------------------------------
    initial begin : run_all
        int send_pcts[4];
        int sink_pcts[4];
        int target;
        send_pcts = '{0, 48, 0, 37};
        sink_pcts = '{0, 0, 48, 37};
        clear_record(32'd0, 1'b0);
        parse_st = c2e_pkg::PH_IDLE;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty record at position -1, lone star, every op letter in mixed case
        // with left and right soft clips at the top position, an unmapped record
        // with an intron, and a star followed by a digit
        start_record(32'hFFFF_FFFF, 1'b0);
        push_char(8'd0, 1'b1);
        start_record(32'd0, 1'b0);
        push_text("*");
        push_char(8'd0, 1'b1);
        start_record(32'h7FFF_FFFF, 1'b0);
        push_text("2S3MNx4d1i1h1p=2s");
        push_char(8'd0, 1'b1);
        start_record(32'd5, 1'b1);
        push_text("1N");
        push_char(8'd0, 1'b1);
        start_record(32'd9, 1'b0);
        push_text("*1");
        push_char(8'd0, 1'b1);
        drain_all();

        // random records under four idling patterns
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = send_pcts[p];
            sink_stall_pct = sink_pcts[p];
            target = chars_queued + 175;
            while (chars_queued < target) begin
                add_record();
                // now and then the sender waits for the pipe to empty
                if ($urandom_range(0, 24) == 0)
                    drain_all();
            end
            drain_all();
        end

        repeat (10) @(posedge i_clk);
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin : hang_guard
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
